/* hdl/wdst_pkg.sv */
// Shared constants for the word distance statistics table.
package wdst_pkg;

    // Default table depth and maximum word length.
    localparam int DEF_TABLE_SLOTS    = 1024;
    localparam int DEF_MAX_WORD_BYTES = 63;

    // Field widths.
    localparam int LEN_W  = 6;
    localparam int POS_W  = 32;
    localparam int STAT_W = 32;

    // Bytes at or below this value are delimiters.
    localparam logic [7:0] DELIM_MAX = 8'd32;

    // Starting value of the djb2 hash.
    localparam logic [31:0] HASH_SEED = 32'd5381;

    // The mean divider handles a 33-bit dividend, one bit per step.
    localparam int DIV_STEPS = 33;
    localparam int DIV_CNT_W = 6;

    // Packed widths of the stream payloads.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 168;
    localparam int M_TUSER_W = 2;

endpackage

/* hdl/word_distance_stats_table_core.sv */
// Word distance statistics table: byte stream in, one statistics beat per word out.
//
// Bytes arrive one per beat on the slave side; values 0 to 32 are delimiters and tlast
// marks the final byte of a text. A byte that ends no word leaves the core idle. At a
// word end the low bits of the djb2 hash pick the first slot, so TABLE_SLOTS must be a
// power of two. Each probe of the table memory passes through a read state, which
// registers the slot, and a compare state; a repeated word then runs through the
// radix-2 divider for its running mean, and a final state hands the result to the
// output register. A word that finds the table full probes every slot before its result
// is flagged full. After reset the table is cleared one slot per cycle, so no byte is
// accepted until every slot is cleared. The output register lets the next bytes enter
// while a result waits; a further result holds until that register is free.
module word_distance_stats_table_core #(
    parameter int TABLE_SLOTS    = wdst_pkg::DEF_TABLE_SLOTS,
    parameter int MAX_WORD_BYTES = wdst_pkg::DEF_MAX_WORD_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // text_byte[7:0]
    input  logic [wdst_pkg::S_TDATA_W-1:0]  s_tdata,
    // end_of_text
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // occurrences[31:0], first_position[63:32], shortest_gap[95:64],
    // longest_gap[127:96], average_gap[159:128], word_length[165:160], zero pad
    output logic [wdst_pkg::M_TDATA_W-1:0]  m_tdata,
    // is_new_word[0], table_full[1]
    output logic [wdst_pkg::M_TUSER_W-1:0]  m_tuser
);

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int PROBE_W = $clog2(TABLE_SLOTS + 1);
    localparam int IDX_W   = $clog2(MAX_WORD_BYTES);
    localparam int KEY_W   = MAX_WORD_BYTES * 8;
    localparam int LEN_W   = wdst_pkg::LEN_W;
    localparam int SW      = wdst_pkg::STAT_W;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic [SW-1:0]    count;
        logic [SW-1:0]    first;
        logic [SW-1:0]    last;
        logic [SW-1:0]    min_gap;
        logic [SW-1:0]    max_gap;
        logic [SW-1:0]    mean_gap;
    } slot_t;

    typedef struct packed {
        logic             is_new;
        logic             full;
        logic [SW-1:0]    occ;
        logic [SW-1:0]    first;
        logic [SW-1:0]    shortest;
        logic [SW-1:0]    longest;
        logic [SW-1:0]    average;
        logic [LEN_W-1:0] len;
    } res_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_MEAN,
        ST_OUT
    } state_t;

    state_t state_reg;

    // Table memory and its registered read data.
    slot_t             mem [TABLE_SLOTS];
    slot_t             rd_data_reg;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    slot_t             mem_wdata;

    logic [SLOT_W-1:0]  clr_idx_reg;
    logic [31:0]        pos_reg;
    logic               started_reg;
    logic [LEN_W-1:0]   pend_len_reg;
    logic [31:0]        pend_hash_reg;
    logic [7:0]         pend_bytes_reg [MAX_WORD_BYTES];
    logic [KEY_W-1:0]   pend_key;

    logic [SLOT_W-1:0]  slot_reg;
    logic [PROBE_W-1:0] probe_cnt_reg;
    logic [SW-1:0]      gap_reg;
    logic               neg_reg;
    res_t               res_reg;

    // Mean divider registers.
    logic [31:0]                  rem_reg;
    logic [32:0]                  quo_reg;
    logic [31:0]                  den_reg;
    logic [wdst_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic               m_tvalid_reg;
    logic [wdst_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [wdst_pkg::M_TUSER_W-1:0] m_tuser_reg;

    // Input byte decode.
    logic [7:0]       in_byte;
    logic             in_delim;
    logic [LEN_W-1:0] len_app;
    logic [31:0]      hash_app;
    logic [31:0]      pos_next;
    logic             accept;

    assign in_byte  = s_tdata[7:0];
    assign in_delim = (in_byte <= wdst_pkg::DELIM_MAX);
    assign len_app  = pend_len_reg + LEN_W'(1);
    assign hash_app = (pend_hash_reg << 5) + pend_hash_reg + {24'd0, in_byte};
    assign pos_next = !started_reg ? 32'd0 :
                      ((pos_reg == '1) ? pos_reg : pos_reg + 32'd1);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        for (int i = 0; i < MAX_WORD_BYTES; i++)
        begin
            pend_key[i*8 +: 8] = pend_bytes_reg[i];
        end
    end

    // One restoring division step.
    logic [32:0] rem_sh;
    logic        div_ge;
    logic [32:0] rem_sub;
    logic [31:0] rem_step;
    logic [32:0] quo_step;

    assign rem_sh   = {rem_reg, quo_reg[32]};
    assign div_ge   = (rem_sh >= {1'b0, den_reg});
    assign rem_sub  = rem_sh - {1'b0, den_reg};
    assign rem_step = div_ge ? rem_sub[31:0] : rem_sh[31:0];
    assign quo_step = {quo_reg[31:0], div_ge};

    // Key compare against the word being looked up, masked to its length.
    logic key_hit;

    always_comb
    begin
        key_hit = (rd_data_reg.len == pend_len_reg);
        for (int i = 0; i < MAX_WORD_BYTES; i++)
        begin
            if ((LEN_W'(i) < pend_len_reg) && (rd_data_reg.key[i*8 +: 8] != pend_bytes_reg[i]))
            begin
                key_hit = 1'b0;
            end
        end
    end

    // Gap and signed distance from the stored mean.
    logic [SW-1:0] gap_calc;
    logic [32:0]   diff_calc;
    logic [32:0]   mag_calc;

    assign gap_calc  = pos_reg - rd_data_reg.last;
    assign diff_calc = {1'b0, gap_calc} - {1'b0, rd_data_reg.mean_gap};
    assign mag_calc  = diff_calc[32] ? (33'd0 - diff_calc) : diff_calc;

    // Updated entry for a repeated word.
    slot_t         upd_slot;
    logic [SW-1:0] q_low;

    always_comb
    begin
        q_low = quo_reg[31:0];
        upd_slot          = rd_data_reg;
        upd_slot.last     = pos_reg;
        upd_slot.mean_gap = rd_data_reg.mean_gap + (neg_reg ? (32'd0 - q_low) : q_low);
        if (rd_data_reg.count != '1)
        begin
            upd_slot.count = rd_data_reg.count + 32'd1;
        end
        if (rd_data_reg.count == 32'd1)
        begin
            upd_slot.min_gap = gap_reg;
            upd_slot.max_gap = gap_reg;
        end
        else
        begin
            if (gap_reg < rd_data_reg.min_gap)
            begin
                upd_slot.min_gap = gap_reg;
            end
            if (gap_reg > rd_data_reg.max_gap)
            begin
                upd_slot.max_gap = gap_reg;
            end
        end
    end

    // New entry for a first occurrence.
    slot_t ins_slot;

    always_comb
    begin
        ins_slot          = '0;
        ins_slot.valid    = 1'b1;
        ins_slot.key      = pend_key;
        ins_slot.len      = pend_len_reg;
        ins_slot.count    = 32'd1;
        ins_slot.first    = pos_reg;
        ins_slot.last     = pos_reg;
    end

    // Memory write port select.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = ins_slot;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
            end
            ST_CHECK:
            begin
                mem_we = !rd_data_reg.valid;
            end
            ST_MEAN:
            begin
                mem_we    = (div_cnt_reg == '0);
                mem_wdata = upd_slot;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Table memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= mem[slot_reg];
        end
    end

    // Pending word bytes.
    always_ff @(posedge clk)
    begin
        if (accept && !in_delim)
        begin
            pend_bytes_reg[pend_len_reg[IDX_W-1:0]] <= in_byte;
        end
    end

    // Control sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            pos_reg       <= '1;
            started_reg   <= 1'b0;
            pend_len_reg  <= '0;
            pend_hash_reg <= wdst_pkg::HASH_SEED;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= '0;
            div_cnt_reg   <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            den_reg       <= '0;
            gap_reg       <= '0;
            neg_reg       <= 1'b0;
            res_reg       <= '0;
            slot_reg      <= '0;
            probe_cnt_reg <= '0;
        end
        else
        begin
            // The output beat leaves unless a new result is loaded in this cycle.
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + SLOT_W'(1);
                    if (clr_idx_reg == SLOT_W'(TABLE_SLOTS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (accept)
                    begin
                        pos_reg       <= pos_next;
                        started_reg   <= 1'b1;
                        probe_cnt_reg <= '0;
                        if (in_delim)
                        begin
                            slot_reg <= pend_hash_reg[SLOT_W-1:0];
                            if (pend_len_reg != '0)
                            begin
                                state_reg <= ST_READ;
                            end
                        end
                        else
                        begin
                            pend_len_reg  <= len_app;
                            pend_hash_reg <= hash_app;
                            slot_reg      <= hash_app[SLOT_W-1:0];
                            if (s_tlast || (len_app == LEN_W'(MAX_WORD_BYTES)))
                            begin
                                state_reg <= ST_READ;
                            end
                        end
                    end
                end

                ST_READ:
                begin
                    if (probe_cnt_reg == PROBE_W'(TABLE_SLOTS))
                    begin
                        res_reg      <= '0;
                        res_reg.full <= 1'b1;
                        res_reg.len  <= pend_len_reg;
                        state_reg    <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_CHECK;
                    end
                end

                ST_CHECK:
                begin
                    if (!rd_data_reg.valid)
                    begin
                        res_reg        <= '0;
                        res_reg.is_new <= 1'b1;
                        res_reg.occ    <= 32'd1;
                        res_reg.first  <= pos_reg;
                        res_reg.len    <= pend_len_reg;
                        state_reg      <= ST_OUT;
                    end
                    else if (key_hit)
                    begin
                        gap_reg     <= gap_calc;
                        neg_reg     <= diff_calc[32];
                        rem_reg     <= '0;
                        quo_reg     <= mag_calc;
                        den_reg     <= rd_data_reg.count;
                        div_cnt_reg <= wdst_pkg::DIV_CNT_W'(wdst_pkg::DIV_STEPS);
                        state_reg   <= ST_MEAN;
                    end
                    else
                    begin
                        slot_reg      <= (slot_reg == SLOT_W'(TABLE_SLOTS - 1)) ?
                                         '0 : slot_reg + SLOT_W'(1);
                        probe_cnt_reg <= probe_cnt_reg + PROBE_W'(1);
                        state_reg     <= ST_READ;
                    end
                end

                ST_MEAN:
                begin
                    if (div_cnt_reg != '0)
                    begin
                        rem_reg     <= rem_step;
                        quo_reg     <= quo_step;
                        div_cnt_reg <= div_cnt_reg - wdst_pkg::DIV_CNT_W'(1);
                    end
                    else
                    begin
                        res_reg.is_new   <= 1'b0;
                        res_reg.full     <= 1'b0;
                        res_reg.occ      <= upd_slot.count;
                        res_reg.first    <= upd_slot.first;
                        res_reg.shortest <= upd_slot.min_gap;
                        res_reg.longest  <= upd_slot.max_gap;
                        res_reg.average  <= upd_slot.mean_gap;
                        res_reg.len      <= pend_len_reg;
                        state_reg        <= ST_OUT;
                    end
                end

                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg  <= 1'b1;
                        m_tuser_reg   <= {res_reg.full, res_reg.is_new};
                        m_tdata_reg   <= {2'b00, res_reg.len, res_reg.average,
                                          res_reg.longest, res_reg.shortest,
                                          res_reg.first, res_reg.occ};
                        pend_len_reg  <= '0;
                        pend_hash_reg <= wdst_pkg::HASH_SEED;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
